[hw/rtl/bbc_pkg.sv]
`default_nettype none

package bbc_pkg;

  // Byte codes of the brackets
  localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;  // (
  localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;  // )
  localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;  // {
  localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;  // }
  localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;  // [
  localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;  // ]

  // Stack entry codes
  localparam logic [1:0] CODE_ROUND  = 2'd0;
  localparam logic [1:0] CODE_CURLY  = 2'd1;
  localparam logic [1:0] CODE_SQUARE = 2'd2;

  // Verdict codes
  localparam logic [1:0] VERDICT_BALANCED   = 2'd0;
  localparam logic [1:0] VERDICT_UNBALANCED = 2'd1;
  localparam logic [1:0] VERDICT_OVERFLOW   = 2'd2;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_OPEN,
    KIND_CLOSE
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] code;
    logic       last;
  } op_t;

endpackage

`default_nettype wire

[hw/rtl/bbc_front.sv]
`default_nettype none

module bbc_front (
  input  wire logic        valid_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_text_i,
  input  wire logic        full_i,
  output logic             stall_o,
  output logic             push_o,
  output bbc_pkg::op_t     op_o
);

  assign stall_o = full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    op_o.last = end_of_text_i;
    op_o.kind = bbc_pkg::KIND_NONE;
    op_o.code = bbc_pkg::CODE_ROUND;
    unique case (char_code_i)
      bbc_pkg::CHAR_ROUND_OPEN: begin
        op_o.kind = bbc_pkg::KIND_OPEN;
        op_o.code = bbc_pkg::CODE_ROUND;
      end
      bbc_pkg::CHAR_CURLY_OPEN: begin
        op_o.kind = bbc_pkg::KIND_OPEN;
        op_o.code = bbc_pkg::CODE_CURLY;
      end
      bbc_pkg::CHAR_SQUARE_OPEN: begin
        op_o.kind = bbc_pkg::KIND_OPEN;
        op_o.code = bbc_pkg::CODE_SQUARE;
      end
      bbc_pkg::CHAR_ROUND_CLOSE: begin
        op_o.kind = bbc_pkg::KIND_CLOSE;
        op_o.code = bbc_pkg::CODE_ROUND;
      end
      bbc_pkg::CHAR_CURLY_CLOSE: begin
        op_o.kind = bbc_pkg::KIND_CLOSE;
        op_o.code = bbc_pkg::CODE_CURLY;
      end
      bbc_pkg::CHAR_SQUARE_CLOSE: begin
        op_o.kind = bbc_pkg::KIND_CLOSE;
        op_o.code = bbc_pkg::CODE_SQUARE;
      end
      default: begin
        op_o.kind = bbc_pkg::KIND_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/bbc_fifo.sv]
`default_nettype none

module bbc_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire bbc_pkg::op_t op_i,
  output logic              full_o,
  output logic              valid_o,
  input  wire logic         pop_i,
  output bbc_pkg::op_t      op_o
);

  localparam int PtrW = bbc_pkg::QUEUE_PTR_W;

  bbc_pkg::op_t        entry_q [bbc_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]       count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(bbc_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign op_o    = entry_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bbc_back.sv]
`default_nettype none

module bbc_back #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  wire bbc_pkg::op_t q_op_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [1:0]        verdict_o
);

  localparam int LvlW  = $clog2(STACK_DEPTH + 1);
  localparam int AddrW = $clog2(STACK_DEPTH);
  localparam logic [LvlW-1:0] LvlFull = LvlW'(STACK_DEPTH);

  // Stack memory; top entry is also held in top_q, and the entry under it
  // is prefetched into rd_data_q every cycle.
  logic [1:0]        stack_mem [STACK_DEPTH];
  logic [1:0]        rd_data_q;
  logic [AddrW-1:0]  rd_addr;
  logic [AddrW-1:0]  wr_addr;
  logic              wr_en;
  logic [LvlW-1:0]   rd_level;

  logic [LvlW-1:0]   level_q, level_d;
  logic [1:0]        top_q, top_d;
  logic              mismatch_q, mismatch_d;
  logic              overflow_q, overflow_d;
  logic              out_valid_q, out_valid_d;
  logic [1:0]        verdict_q, verdict_d;
  logic              do_step;
  logic              top_match;

  assign do_step   = q_valid_i && (!q_op_i.last || !out_valid_q || !out_stall_i);
  assign q_pop_o   = do_step;
  assign top_match = (level_q != '0) && (top_q == q_op_i.code);

  always_comb begin
    level_d     = level_q;
    top_d       = top_q;
    mismatch_d  = mismatch_q;
    overflow_d  = overflow_q;
    wr_en       = 1'b0;
    wr_addr     = level_q[AddrW-1:0];
    out_valid_d = out_valid_q && out_stall_i;
    verdict_d   = verdict_q;

    if (do_step) begin
      case (q_op_i.kind)
        bbc_pkg::KIND_OPEN: begin
          if (level_q == LvlFull) begin
            overflow_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            level_d = level_q + 1'b1;
            top_d   = q_op_i.code;
          end
        end
        bbc_pkg::KIND_CLOSE: begin
          if (top_match) begin
            level_d = level_q - 1'b1;
            top_d   = rd_data_q;
          end else begin
            mismatch_d = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (q_op_i.last) begin
        out_valid_d = 1'b1;
        if (overflow_d) begin
          verdict_d = bbc_pkg::VERDICT_OVERFLOW;
        end else if (mismatch_d || (level_d != '0)) begin
          verdict_d = bbc_pkg::VERDICT_UNBALANCED;
        end else begin
          verdict_d = bbc_pkg::VERDICT_BALANCED;
        end
        level_d    = '0;
        mismatch_d = 1'b0;
        overflow_d = 1'b0;
      end
    end

    // entry just below the next top; garbage below two entries is never used
    rd_level = level_d - LvlW'(2);
    rd_addr  = rd_level[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      mismatch_q  <= 1'b0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      mismatch_q  <= mismatch_d;
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q     <= top_d;
    verdict_q <= verdict_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= q_op_i.code;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LvlFull)
    else $error("stack level beyond depth");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && q_op_i.last) |=> (level_q == '0 && !mismatch_q && !overflow_q
                                  && out_valid_q))
    else $error("state not cleared after end of text");

  a_overflow_on_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && !q_op_i.last && q_op_i.kind == bbc_pkg::KIND_OPEN
     && level_q == LvlFull) |=> (overflow_q && level_q == LvlFull))
    else $error("push on full stack not flagged");

endmodule

`default_nettype wire

[hw/rtl/bracket_balance_checker.sv]
`default_nettype none

// Bracket balance checker. Takes one text byte per cycle while in_stall_o is
// low; the byte with end_of_text set closes a string and yields one verdict
// (0 balanced, 1 unbalanced, 2 stack overflow), other bytes yield nothing.
// A decoder in front classifies each byte and drops it into a 4-entry
// request queue; the stack engine behind it does one push or pop per cycle,
// with the top entry in a register and the entry below it read ahead from
// the stack memory, so the sustained rate is one byte per cycle unless a
// final byte waits on a stalled verdict. A final byte passes the request
// queue and then the stack engine, which registers its verdict; the next
// string can follow at once. The stack needs no clearing pass after reset.
module bracket_balance_checker #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       verdict_o
);

  logic          q_full;
  logic          q_push;
  bbc_pkg::op_t  front_op;
  logic          q_valid;
  logic          q_pop;
  bbc_pkg::op_t  back_op;

  bbc_front u_front (
    .valid_i       (in_valid_i),
    .char_code_i   (char_code_i),
    .end_of_text_i (end_of_text_i),
    .full_i        (q_full),
    .stall_o       (in_stall_o),
    .push_o        (q_push),
    .op_o          (front_op)
  );

  bbc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (front_op),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .op_o    (back_op)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (back_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .verdict_o   (verdict_o)
  );

endmodule

`default_nettype wire
